// ----- sv/pat_pkg.sv -----
package pat_pkg;

    localparam int INDEX_BITS_DEFAULT  = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int COUNTER_W = 32;
    localparam int TAG_W     = 16;
    localparam int BIND_W    = 2;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Bits of a queue word beyond the six corner fields.
    localparam int ENTRY_EXTRA_W = TAG_W + COUNTER_W + 2;

    localparam logic [MODE_W-1:0] MODE_TRIS       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STRIP      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUADS      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUAD_STRIP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAN        = 3'd4;

    localparam logic [BIND_W-1:0] BIND_VERTEX_NORMALS = 2'd1;
    localparam logic [BIND_W-1:0] BIND_PER_SET        = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_BINDING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAWABLE_ID    = 2'd1;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- sv/pat_front.sv -----
module pat_front #(
    parameter int INDEX_BITS = pat_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [31:0]                     vertex_index,
    input  logic [pat_pkg::MODE_W-1:0]      prim_mode,
    input  logic                            last_of_set,
    input  logic                            cfg_write,
    input  logic [pat_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pat_pkg::TAG_W-1:0]       cfg_data,
    input  pat_pkg::q_status_t              q_status,
    output logic                            in_stall,
    output logic                            push,
    output logic [6*INDEX_BITS+pat_pkg::ENTRY_EXTRA_W-1:0] push_word
);

    localparam int IW = INDEX_BITS;

    logic [IW-1:0]                      prev_one_reg, prev_one_next;
    logic [IW-1:0]                      prev_two_reg, prev_two_next;
    logic [IW-1:0]                      prev_three_reg, prev_three_next;
    logic [IW-1:0]                      anchor_reg, anchor_next;
    logic [pat_pkg::COUNTER_W-1:0]      pos_reg, pos_next;
    logic [1:0]                         pos3_reg, pos3_next;
    logic [pat_pkg::COUNTER_W-1:0]      ncnt_reg, ncnt_next;
    logic [pat_pkg::BIND_W-1:0]         binding_reg, binding_next;
    logic [pat_pkg::TAG_W-1:0]          tag_reg, tag_next;

    logic          in_fire;
    logic [IW-1:0] v;
    logic [IW-1:0] t0a, t0b, t0c, t1a, t1b, t1c;
    logic          hit;
    logic          pair;

    assign in_stall = q_status.full;
    assign in_fire  = in_valid & ~q_status.full;
    assign v        = vertex_index[IW-1:0];

    always_comb
    begin
        t0a  = prev_two_reg;
        t0b  = prev_one_reg;
        t0c  = v;
        t1a  = prev_three_reg;
        t1b  = prev_one_reg;
        t1c  = v;
        hit  = 1'b0;
        pair = 1'b0;
        case (prim_mode)
            pat_pkg::MODE_TRIS:
            begin
                hit = (pos3_reg == 2'd2);
            end
            pat_pkg::MODE_STRIP:
            begin
                hit = (pos_reg >= 32'd2);
                if (pos_reg[0])
                begin
                    t0b = v;
                    t0c = prev_one_reg;
                end
            end
            pat_pkg::MODE_QUADS:
            begin
                hit  = (pos_reg[1:0] == 2'd3);
                pair = 1'b1;
                t0a  = prev_three_reg;
                t0b  = prev_two_reg;
                t0c  = prev_one_reg;
            end
            pat_pkg::MODE_QUAD_STRIP:
            begin
                hit  = (pos_reg >= 32'd3) && pos_reg[0];
                pair = 1'b1;
                t0a  = prev_three_reg;
                t0b  = prev_two_reg;
                t0c  = prev_one_reg;
                t1a  = prev_two_reg;
                t1b  = v;
                t1c  = prev_one_reg;
            end
            pat_pkg::MODE_FAN:
            begin
                hit = (pos_reg >= 32'd2);
                t0a = anchor_reg;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign push      = in_fire & hit;
    assign push_word = {tag_reg, ncnt_reg, (binding_reg == pat_pkg::BIND_VERTEX_NORMALS), pair,
                        t1c, t1b, t1a, t0c, t0b, t0a};

    always_comb
    begin
        prev_one_next   = prev_one_reg;
        prev_two_next   = prev_two_reg;
        prev_three_next = prev_three_reg;
        anchor_next     = anchor_reg;
        pos_next        = pos_reg;
        pos3_next       = pos3_reg;
        ncnt_next       = ncnt_reg;
        binding_next    = binding_reg;
        tag_next        = tag_reg;
        if (cfg_write)
        begin
            if (cfg_index == pat_pkg::CFG_NORMAL_BINDING)
            begin
                binding_next = cfg_data[pat_pkg::BIND_W-1:0];
                ncnt_next    = '0;
            end
            else if (cfg_index == pat_pkg::CFG_DRAWABLE_ID)
            begin
                tag_next  = cfg_data;
                ncnt_next = '0;
            end
        end
        else if (in_fire)
        begin
            prev_three_next = prev_two_reg;
            prev_two_next   = prev_one_reg;
            prev_one_next   = v;
            if (pos_reg == '0)
            begin
                anchor_next = v;
            end
            if (last_of_set)
            begin
                if (binding_reg == pat_pkg::BIND_PER_SET)
                begin
                    ncnt_next = ncnt_reg + 1'b1;
                end
                pos_next  = '0;
                pos3_next = 2'd0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                // The position counter wraps to zero, so its residue does too.
                if (pos_reg == '1 || pos3_reg == 2'd2)
                begin
                    pos3_next = 2'd0;
                end
                else
                begin
                    pos3_next = pos3_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_one_reg   <= '0;
            prev_two_reg   <= '0;
            prev_three_reg <= '0;
            anchor_reg     <= '0;
            pos_reg        <= '0;
            pos3_reg       <= '0;
            ncnt_reg       <= '0;
            binding_reg    <= '0;
            tag_reg        <= '0;
        end
        else
        begin
            prev_one_reg   <= prev_one_next;
            prev_two_reg   <= prev_two_next;
            prev_three_reg <= prev_three_next;
            anchor_reg     <= anchor_next;
            pos_reg        <= pos_next;
            pos3_reg       <= pos3_next;
            ncnt_reg       <= ncnt_next;
            binding_reg    <= binding_next;
            tag_reg        <= tag_next;
        end
    end

endmodule

// ----- sv/pat_queue.sv -----
module pat_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pat_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_word,
    input  logic               pop,
    output logic [WIDTH-1:0]   head_word,
    output pat_pkg::q_status_t q_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign head_word      = mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/pat_back.sv -----
module pat_back #(
    parameter int INDEX_BITS = pat_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic [6*INDEX_BITS+pat_pkg::ENTRY_EXTRA_W-1:0] head_word,
    input  pat_pkg::q_status_t                             q_status,
    input  logic                                           out_stall,
    output logic                                           pop,
    output logic                                           out_valid,
    output logic [31:0]                                    corner_a,
    output logic [31:0]                                    corner_b,
    output logic [31:0]                                    corner_c,
    output logic [31:0]                                    normal_a,
    output logic [31:0]                                    normal_b,
    output logic [31:0]                                    normal_c,
    output logic [pat_pkg::TAG_W-1:0]                      geometry_tag,
    output logic                                           last_of_run
);

    localparam int IW       = INDEX_BITS;
    localparam int PAIR_BIT = 6 * IW;
    localparam int PV_BIT   = 6 * IW + 1;
    localparam int NCNT_LO  = 6 * IW + 2;
    localparam int TAG_LO   = NCNT_LO + pat_pkg::COUNTER_W;

    logic                          out_valid_reg, out_valid_next;
    logic                          sub_reg, sub_next;
    logic [IW-1:0]                 ca_reg, cb_reg, cc_reg;
    logic [31:0]                   na_reg, nb_reg, nc_reg;
    logic [pat_pkg::TAG_W-1:0]     tag_reg;
    logic                          last_reg;

    logic                          load;
    logic                          pair;
    logic                          per_vertex;
    logic                          is_last;
    logic [IW-1:0]                 sa, sb, sc;
    logic [pat_pkg::COUNTER_W-1:0] ncnt;

    assign pair       = head_word[PAIR_BIT];
    assign per_vertex = head_word[PV_BIT];
    assign ncnt       = head_word[NCNT_LO +: pat_pkg::COUNTER_W];
    assign sa         = sub_reg ? head_word[3*IW +: IW] : head_word[0    +: IW];
    assign sb         = sub_reg ? head_word[4*IW +: IW] : head_word[IW   +: IW];
    assign sc         = sub_reg ? head_word[5*IW +: IW] : head_word[2*IW +: IW];
    assign is_last    = ~pair | sub_reg;

    assign load = ~q_status.empty & (~out_valid_reg | ~out_stall);
    assign pop  = load & is_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sub_next       = sub_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            sub_next       = ~is_last;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ca_reg   <= sa;
            cb_reg   <= sb;
            cc_reg   <= sc;
            na_reg   <= per_vertex ? 32'(sa) : ncnt;
            nb_reg   <= per_vertex ? 32'(sb) : ncnt;
            nc_reg   <= per_vertex ? 32'(sc) : ncnt;
            tag_reg  <= head_word[TAG_LO +: pat_pkg::TAG_W];
            last_reg <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign corner_a     = 32'(ca_reg);
    assign corner_b     = 32'(cb_reg);
    assign corner_c     = 32'(cc_reg);
    assign normal_a     = na_reg;
    assign normal_b     = nb_reg;
    assign normal_c     = nc_reg;
    assign geometry_tag = tag_reg;
    assign last_of_run  = last_reg;

endmodule

// ----- sv/primitive_assembly_triangulator.sv -----
// Primitive assembly: turns a stream of vertex indices into triangles.
// Input channel (in_valid/in_stall) carries one vertex word per cycle while in_stall is low, with its
// primitive mode and an end-of-set flag. Output channel (out_valid/out_stall)
// carries one triangle word: three corners, three normal indices, the geometry
// tag, and last_of_run on the final triangle caused by an input word.
// The user must write configuration through cfg_write/cfg_index/cfg_data only while idle;
// the block does not enforce this. Any write to a defined register also clears the per-set normal counter.
// An accepted input word that yields triangles is written into the queue and
// then loaded into the output register. The input takes one word per cycle while
// in_stall is low; a quad or quad-strip word yields two triangles, which the single
// output register sends one after the other before the queued word is popped.
// Words that yield no triangle only advance the history and position and never queue.
// Reset clears the vertex history, position, counter and both registers.
// When the receiver stalls, the output word holds, the queue fills, and
// in_stall rises once the queue is full.
module primitive_assembly_triangulator #(
    parameter int INDEX_BITS  = pat_pkg::INDEX_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = pat_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [31:0]                   vertex_index,
    input  logic [pat_pkg::MODE_W-1:0]    prim_mode,
    input  logic                          last_of_set,
    input  logic                          cfg_write,
    input  logic [pat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pat_pkg::TAG_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [31:0]                   corner_a,
    output logic [31:0]                   corner_b,
    output logic [31:0]                   corner_c,
    output logic [31:0]                   normal_a,
    output logic [31:0]                   normal_b,
    output logic [31:0]                   normal_c,
    output logic [pat_pkg::TAG_W-1:0]     geometry_tag,
    output logic                          last_of_run
);

    localparam int ENTRY_W = 6 * INDEX_BITS + pat_pkg::ENTRY_EXTRA_W;

    pat_pkg::q_status_t   q_status;
    logic                 push;
    logic                 pop;
    logic [ENTRY_W-1:0]   push_word;
    logic [ENTRY_W-1:0]   head_word;

    pat_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .vertex_index (vertex_index),
        .prim_mode    (prim_mode),
        .last_of_set  (last_of_set),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_status     (q_status),
        .in_stall     (in_stall),
        .push         (push),
        .push_word    (push_word)
    );

    pat_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .q_status  (q_status)
    );

    pat_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_word    (head_word),
        .q_status     (q_status),
        .out_stall    (out_stall),
        .pop          (pop),
        .out_valid    (out_valid),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .normal_a     (normal_a),
        .normal_b     (normal_b),
        .normal_c     (normal_c),
        .geometry_tag (geometry_tag),
        .last_of_run  (last_of_run)
    );

    // A word enters the queue only on an accepted input.
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (in_valid && !in_stall))
        else $error("queue push without accepted input");

    // The second triangle of a pair follows right after the first is taken.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=> out_valid)
        else $error("second triangle of a pair did not follow");

    // Popping requires a queued word.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [pat_pkg::MODE_W-1:0]    mode_t;
    typedef logic [pat_pkg::BIND_W-1:0]    bind_t;
    typedef logic [pat_pkg::CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [pat_pkg::TAG_W-1:0]     tag_t;

    localparam mode_t    MODE_POINTS = 3'd5;
    localparam mode_t    MODE_SPARE6 = 3'd6;
    localparam mode_t    MODE_SPARE7 = 3'd7;
    localparam bind_t    BIND_NONE   = 2'd0;
    localparam bind_t    BIND_SPARE  = 2'd3;
    localparam cfg_idx_t CFG_SPARE2  = 2'd2;
    localparam cfg_idx_t CFG_SPARE3  = 2'd3;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [2:0][31:0]  corner;
        logic [2:0][31:0]  normal;
        tag_t              tag;
        logic              last;
    } triangle_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [31:0]          vertex_index = '0;
    mode_t                prim_mode = '0;
    logic                 last_of_set = 1'b0;
    logic                 cfg_write = 1'b0;
    cfg_idx_t             cfg_index = '0;
    tag_t                 cfg_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [31:0]          corner_a;
    logic [31:0]          corner_b;
    logic [31:0]          corner_c;
    logic [31:0]          normal_a;
    logic [31:0]          normal_b;
    logic [31:0]          normal_c;
    tag_t                 geometry_tag;
    logic                 last_of_run;

    // Predictor state.
    bind_t       binding_reg = '0;
    tag_t        tag_reg = '0;
    logic [31:0] hist1 = '0;
    logic [31:0] hist2 = '0;
    logic [31:0] hist3 = '0;
    logic [31:0] anchor = '0;
    logic [31:0] set_pos = '0;
    logic [31:0] set_normal_idx = '0;

    triangle_t expected_tris[$];

    bit quiet = 1'b0;
    int stall_left = 0;
    int errors = 0;
    int words_sent = 0;
    int sets_sent = 0;
    int tris_checked = 0;

    primitive_assembly_triangulator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .vertex_index (vertex_index),
        .prim_mode    (prim_mode),
        .last_of_set  (last_of_set),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .normal_a     (normal_a),
        .normal_b     (normal_b),
        .normal_c     (normal_c),
        .geometry_tag (geometry_tag),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic triangle_t make_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        triangle_t t;
        t.corner = {c, b, a};
        if (binding_reg == pat_pkg::BIND_VERTEX_NORMALS)
            t.normal = {c, b, a};
        else
            t.normal = {3{set_normal_idx}};
        t.tag = tag_reg;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic void assemble_vertex(logic [31:0] v, mode_t m, logic l);
        triangle_t made[$];
        logic [31:0] p;
        p = set_pos;
        if (p == 0)
            anchor = v;
        case (m)
            pat_pkg::MODE_TRIS:
                if (p % 3 == 2)
                    made = {made, make_triangle(hist2, hist1, v)};
            pat_pkg::MODE_STRIP:
                if (p >= 2)
                begin
                    if (p[0])
                        made = {made, make_triangle(hist2, v, hist1)};
                    else
                        made = {made, make_triangle(hist2, hist1, v)};
                end
            pat_pkg::MODE_QUADS:
                if (p[1:0] == 2'd3)
                begin
                    made = {made, make_triangle(hist3, hist2, hist1)};
                    made = {made, make_triangle(hist3, hist1, v)};
                end
            pat_pkg::MODE_QUAD_STRIP:
                if (p >= 3 && p[0])
                begin
                    made = {made, make_triangle(hist3, hist2, hist1)};
                    made = {made, make_triangle(hist2, v, hist1)};
                end
            pat_pkg::MODE_FAN:
                if (p >= 2)
                    made = {made, make_triangle(anchor, hist1, v)};
            default:
                ;
        endcase
        if (made.size() > 0)
            made[made.size() - 1].last = 1'b1;
        expected_tris = {expected_tris, made};
        hist3 = hist2;
        hist2 = hist1;
        hist1 = v;
        if (l)
        begin
            if (binding_reg == pat_pkg::BIND_PER_SET)
                set_normal_idx = set_normal_idx + 1;
            set_pos = '0;
        end
        else
        begin
            set_pos = p + 1;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_triangles
        triangle_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tris.size() == 0)
            begin
                $display("%0t ns: unexpected triangle, expected none, actual %h %h %h",
                         $time, corner_a, corner_b, corner_c);
                errors++;
            end
            else
            begin
                want = expected_tris.pop_front();
                check_field("corner_a", want.corner[0], corner_a);
                check_field("corner_b", want.corner[1], corner_b);
                check_field("corner_c", want.corner[2], corner_c);
                check_field("normal_a", want.normal[0], normal_a);
                check_field("normal_b", want.normal[1], normal_b);
                check_field("normal_c", want.normal[2], normal_c);
                check_field("geometry_tag", 32'(want.tag), 32'(geometry_tag));
                check_field("last_of_run", 32'(want.last), 32'(last_of_run));
                tris_checked++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(99) < 3)
        begin
            stall_left <= $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_vertex(input logic [31:0] v, input mode_t m, input logic l);
        int gap;
        if (!quiet && $urandom_range(99) < 4)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        vertex_index <= v;
        prim_mode <= m;
        last_of_set <= l;
        do @(posedge clk); while (in_stall);
        assemble_vertex(v, m, l);
        words_sent++;
        if (l)
            sets_sent++;
    endtask

    task automatic await_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tris.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input tag_t data);
        await_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == pat_pkg::CFG_NORMAL_BINDING)
        begin
            binding_reg = data[pat_pkg::BIND_W-1:0];
            set_normal_idx = '0;
        end
        else if (idx == pat_pkg::CFG_DRAWABLE_ID)
        begin
            tag_reg = data;
            set_normal_idx = '0;
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] pick_index();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(63);
            default: return $urandom;
        endcase
    endfunction

    function automatic int set_length(mode_t m);
        int units;
        units = $urandom_range(1, 3);
        case (m)
            pat_pkg::MODE_TRIS:       return 3 * units;
            pat_pkg::MODE_STRIP:      return $urandom_range(3, 8);
            pat_pkg::MODE_QUADS:      return 4 * units;
            pat_pkg::MODE_QUAD_STRIP: return 2 * units + 2;
            pat_pkg::MODE_FAN:        return $urandom_range(3, 8);
            default:                  return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic send_set(input mode_t m, input int len, input bit mixed);
        mode_t word_mode;
        for (int k = 0; k < len; k++)
        begin
            word_mode = m;
            if (mixed && $urandom_range(4) == 0)
                word_mode = mode_t'($urandom_range(7));
            send_vertex(pick_index(), word_mode, k == len - 1);
        end
    endtask

    task automatic test_primitives();
        // Reset settings: counter normals and a zero tag.
        send_vertex(32'h0000_0000, pat_pkg::MODE_TRIS, 1'b0);
        send_vertex(32'hFFFF_FFFF, pat_pkg::MODE_TRIS, 1'b0);
        send_vertex(32'hA5A5_A5A5, pat_pkg::MODE_TRIS, 1'b1);
        write_reg(pat_pkg::CFG_NORMAL_BINDING, {14'h0000, pat_pkg::BIND_VERTEX_NORMALS});
        write_reg(pat_pkg::CFG_DRAWABLE_ID, 16'hFFFF);
        // An incomplete trailing triangle is dropped.
        send_vertex(32'h5A5A_5A5A, pat_pkg::MODE_TRIS, 1'b0);
        send_vertex(32'h0000_0001, pat_pkg::MODE_TRIS, 1'b1);
        send_vertex(32'h0000_0010, pat_pkg::MODE_STRIP, 1'b0);
        send_vertex(32'h0000_0011, pat_pkg::MODE_STRIP, 1'b0);
        send_vertex(32'h0000_0012, pat_pkg::MODE_STRIP, 1'b0);
        send_vertex(32'h0000_0013, pat_pkg::MODE_STRIP, 1'b1);
        send_vertex(32'h0000_0020, pat_pkg::MODE_QUADS, 1'b0);
        send_vertex(32'h0000_0021, pat_pkg::MODE_QUADS, 1'b0);
        send_vertex(32'h0000_0022, pat_pkg::MODE_QUADS, 1'b0);
        send_vertex(32'hFFFF_FFFE, pat_pkg::MODE_QUADS, 1'b1);
        send_vertex(32'h0000_0030, pat_pkg::MODE_QUAD_STRIP, 1'b0);
        send_vertex(32'h0000_0031, pat_pkg::MODE_QUAD_STRIP, 1'b0);
        send_vertex(32'h0000_0032, pat_pkg::MODE_QUAD_STRIP, 1'b0);
        send_vertex(32'h0000_0033, pat_pkg::MODE_QUAD_STRIP, 1'b1);
        send_vertex(32'h8000_0000, pat_pkg::MODE_FAN, 1'b0);
        send_vertex(32'h0000_0041, pat_pkg::MODE_FAN, 1'b0);
        send_vertex(32'h0000_0042, pat_pkg::MODE_FAN, 1'b0);
        send_vertex(32'h7FFF_FFFF, pat_pkg::MODE_FAN, 1'b1);
        // Unused modes advance the history, and a mode change is judged per word.
        send_vertex(32'h0000_0050, MODE_POINTS, 1'b0);
        send_vertex(32'h0000_0051, MODE_SPARE6, 1'b0);
        send_vertex(32'h0000_0052, MODE_SPARE7, 1'b0);
        send_vertex(32'h0000_0053, pat_pkg::MODE_QUADS, 1'b1);
    endtask

    task automatic test_registers();
        write_reg(pat_pkg::CFG_NORMAL_BINDING, {14'h3FFF, pat_pkg::BIND_PER_SET});
        write_reg(pat_pkg::CFG_DRAWABLE_ID, 16'h0000);
        repeat (3) send_set(pat_pkg::MODE_FAN, 3, 1'b0);
        send_set(MODE_POINTS, 2, 1'b0);
        // Writes to undefined indexes must leave the counter alone.
        write_reg(CFG_SPARE2, 16'hFFFF);
        write_reg(CFG_SPARE3, 16'h5A5A);
        send_set(pat_pkg::MODE_TRIS, 3, 1'b0);
        write_reg(pat_pkg::CFG_DRAWABLE_ID, 16'hA5C3);
        send_set(pat_pkg::MODE_STRIP, 4, 1'b0);
        write_reg(pat_pkg::CFG_NORMAL_BINDING, 16'hFFFF);
        send_set(pat_pkg::MODE_QUADS, 4, 1'b0);
        send_set(pat_pkg::MODE_QUAD_STRIP, 6, 1'b0);
        write_reg(pat_pkg::CFG_NORMAL_BINDING, {14'h0000, BIND_NONE});
        send_set(pat_pkg::MODE_TRIS, 3, 1'b0);
    endtask

    task automatic random_sets(input int target);
        int useful;
        int len;
        int roll;
        mode_t m;
        useful = 0;
        while (useful < target)
        begin
            if ($urandom_range(9) == 0)
                m = mode_t'($urandom_range(5, 7));
            else
                m = mode_t'($urandom_range(4));
            len = set_length(m);
            roll = $urandom_range(99);
            if (roll < 8)
                len = $urandom_range(1, 2);
            else if (roll < 15)
                len = len + ($urandom_range(1) ? 1 : -1);
            if (len < 1)
                len = 1;
            send_set(m, len, roll >= 85);
            if (m <= pat_pkg::MODE_FAN)
                useful += len;
        end
    endtask

    task automatic test_random();
        write_reg(pat_pkg::CFG_NORMAL_BINDING, {14'($urandom_range(16'h3FFF)), BIND_NONE});
        write_reg(pat_pkg::CFG_DRAWABLE_ID, tag_t'($urandom_range(16'hFFFF)));
        random_sets(400);
        write_reg(pat_pkg::CFG_NORMAL_BINDING,
                  {14'($urandom_range(16'h3FFF)), pat_pkg::BIND_VERTEX_NORMALS});
        quiet = 1'b1;
        random_sets(400);
        quiet = 1'b0;
        write_reg(pat_pkg::CFG_NORMAL_BINDING,
                  {14'($urandom_range(16'h3FFF)), pat_pkg::BIND_PER_SET});
        write_reg(pat_pkg::CFG_DRAWABLE_ID, 16'hFFFF);
        random_sets(400);
        write_reg(pat_pkg::CFG_NORMAL_BINDING, {14'($urandom_range(16'h3FFF)), BIND_SPARE});
        write_reg(pat_pkg::CFG_DRAWABLE_ID, tag_t'($urandom_range(16'hFFFF)));
        random_sets(400);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_primitives();
        test_registers();
        test_random();
        await_idle();
        $display("Sent %0d vertex words in %0d sets; checked %0d triangles.",
                 words_sent, sets_sent, tris_checked);
        $display("All five assembly modes, unused modes and all binding codes were exercised.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d triangles still expected.", expected_tris.size());
        $display("status: fail");
        $finish;
    end

endmodule
